>>> hdl/unique_random_draw_with_exclusion_unit_macros.svh
// Assertion macros for the checker file of the draw unit.
// Each macro expects the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef UNIQUE_RANDOM_DRAW_WITH_EXCLUSION_UNIT_MACROS_SVH
`define UNIQUE_RANDOM_DRAW_WITH_EXCLUSION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define URD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/urd_pkg.sv
`timescale 1ns / 1ps

package urd_pkg;

    localparam int VAL_W         = 15;
    localparam int CFG_W         = 15;
    localparam int CFG_IDX_W     = 2;
    localparam int DCNT_W        = 9;
    localparam int SPAN_W        = 16;
    localparam int IDX_OUT_W     = 8;
    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_VALUE_MAX = 32767;

    // Function codes of an input transaction. The code with both bits set
    // is an offer as well.
    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_OFFER = 2'd2
    } t_func;

    typedef enum logic [3:0] {
        ST_ACCEPTED   = 4'd0,
        ST_OUT_BAND   = 4'd1,
        ST_DUPLICATE  = 4'd2,
        ST_EXC_STORED = 4'd3,
        ST_LOW_HIGH   = 4'd4,
        ST_TOO_MANY   = 4'd5,
        ST_OVER_MAX   = 4'd6,
        ST_EXC_REPEAT = 4'd7,
        ST_COMPLETE   = 4'd8,
        ST_CLEARED    = 4'd9
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_LOW  = 2'd0,
        REG_RANGE_HIGH = 2'd1,
        REG_DRAW_COUNT = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_L0,
        S_R0,
        S_BAND,
        S_MAP,
        S_SEARCH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]       func;
        logic [VAL_W-1:0] value;
    } t_item;

    typedef struct packed {
        t_status              status;
        logic [VAL_W-1:0]     drawn_value;
        logic [IDX_OUT_W-1:0] draw_index;
        logic                 last_draw;
    } t_result;

    // Control of one ring of storage cells.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

>>> hdl/urd_cell.sv
`timescale 1ns / 1ps

// One entry of a storage ring. It either takes the write data when it is
// the selected entry, or takes its neighbor's value when the ring rotates.
module urd_cell import urd_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_sel,
    input  logic [VAL_W-1:0] i_next,
    input  logic [VAL_W-1:0] i_wr_data,
    output logic [VAL_W-1:0] o_value
);

    logic [VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_sel) begin
            r_value <= i_wr_data;
        end else if (i_ctl.shift) begin
            r_value <= i_next;
        end
    end

    assign o_value = r_value;

endmodule

>>> hdl/urd_div.sv
`timescale 1ns / 1ps

// Restoring divider that yields the remainder, one dividend bit per cycle.
module urd_div import urd_pkg::*; #(
    parameter int DW = SPAN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_dsr;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] n_rem;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;

    always_comb begin
        rem_sh = {r_rem, r_dvd[DW-1]};
        diff   = rem_sh - {1'b0, r_dsr};
        n_rem  = (rem_sh >= {1'b0, r_dsr}) ? diff[DW-1:0] : rem_sh[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> hdl/unique_random_draw_with_exclusion_unit.sv
`timescale 1ns / 1ps
// A clear, a full exclusion list and a failed offer check answer in the cycle after start.
// An exclusion add answers after one full ring rotation.
// An offer answers after three remainder divisions and a ring rotation; an out-of-band word
// answers after the first two divisions and the band check.
// Throughput: one transaction at a time; busy stays high until its result strobe.
// Synchronous active-low reset clears totals and flags and reloads the configuration registers.

// Draws distinct values from [range_low, range_high] by rejection sampling on
// raw random words, skipping values on an exclusion list.
//
// The drawn values and the exclusion values each live in a ring of CAPACITY
// storage cells. To search, both rings rotate one position per cycle for a
// full turn, so every entry passes the head cell once and the ring ends up
// where it started; the head is compared against the search key and entries
// at or beyond the current total are ignored. Appends write the selected cell
// directly. Cell contents are never cleared: a clear zeroes the totals and
// the repeat flag, so stale contents are never looked at.
//
// An offered word is first checked against the configuration. Then one shared
// divider computes, in turn, low mod span, the remainder that sets the top of
// the unbiased band, and the mapped value (word - l0) mod span.
module unique_random_draw_with_exclusion_unit import urd_pkg::*; #(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int VALUE_MAX = DEF_VALUE_MAX
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    output logic                 o_result_valid,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int VW    = $clog2(VALUE_MAX + 1);
    localparam int DW    = (VW > SPAN_W) ? VW : SPAN_W;
    localparam int SUM_W = ((CNT_W > DCNT_W) ? CNT_W : DCNT_W) + 1;
    localparam int CMP_W = (SUM_W > DW) ? SUM_W : DW;

    // Configuration registers.
    logic [VAL_W-1:0]  r_low;
    logic [VAL_W-1:0]  r_high;
    logic [DCNT_W-1:0] r_draw_count;

    // Control state.
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_drawn_total, n_drawn_total;
    logic [CNT_W-1:0]  r_exc_total, n_exc_total;
    logic              r_repeat, n_repeat;
    logic              r_mode_offer, n_mode_offer;
    logic [IDX_W-1:0]  r_step, n_step;
    logic              r_hit, n_hit;
    logic              r_res_valid, n_res_valid;

    // Datapath registers.
    logic [VAL_W-1:0]  r_word, n_word;
    logic [VAL_W-1:0]  r_key, n_key;
    logic [DW-1:0]     r_l0, n_l0;
    logic [DW-1:0]     r_r0, n_r0;
    t_result           r_result, n_result;

    // Divider interface.
    logic              div_start;
    logic [DW-1:0]     div_dividend;
    logic              div_done;
    logic [DW-1:0]     div_rem;

    // Storage rings.
    t_cell_ctl         drawn_ctl;
    t_cell_ctl         exc_ctl;
    logic [IDX_W-1:0]  wr_idx;
    logic [VAL_W-1:0]  drawn_q [CAPACITY];
    logic [VAL_W-1:0]  exc_q [CAPACITY];

    // Decode and checks.
    logic              accept;
    logic              is_clear;
    logic              is_add;
    logic              is_offer;
    logic [SPAN_W-1:0] span;
    logic              bad_order;
    logic              too_many;
    logic              over_max;
    logic              done_all;
    logic              offer_fail;
    logic              exc_full;
    logic              out_band;
    logic              drawn_hit;
    logic              exc_hit;
    logic              step_last;

    assign accept   = start && !busy;
    assign is_clear = (i_item.func == FUNC_CLEAR);
    assign is_add   = (i_item.func == FUNC_ADD);
    // Any code with the upper bit set is an offer.
    assign is_offer = !is_clear && !is_add;

    always_comb begin
        span       = SPAN_W'(r_high) - SPAN_W'(r_low) + SPAN_W'(1);
        bad_order  = (r_low > r_high);
        too_many   = (CMP_W'(r_draw_count) > CMP_W'(CAPACITY))
                  || (CMP_W'(r_draw_count) + CMP_W'(r_exc_total) > CMP_W'(span));
        over_max   = (DW'(r_high) > DW'(VALUE_MAX));
        done_all   = (CMP_W'(r_drawn_total) >= CMP_W'(r_draw_count));
        offer_fail = bad_order || too_many || over_max || r_repeat || done_all;
        exc_full   = (r_exc_total >= CNT_W'(CAPACITY));
        out_band   = (DW'(r_word) < r_l0) || (DW'(r_word) > r_r0);
        drawn_hit  = (drawn_q[0] == r_key) && (CNT_W'(r_step) < r_drawn_total);
        exc_hit    = (exc_q[0] == r_key) && (CNT_W'(r_step) < r_exc_total);
        step_last  = (r_step == IDX_W'(CAPACITY - 1));
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_offer && !offer_fail) begin
                        n_state = S_L0;
                    end else if (is_add && !exc_full) begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_L0: begin
                if (div_done) begin
                    n_state = S_R0;
                end
            end
            S_R0: begin
                if (div_done) begin
                    n_state = S_BAND;
                end
            end
            S_BAND: begin
                n_state = out_band ? S_IDLE : S_MAP;
            end
            S_MAP: begin
                if (div_done) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (step_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and result logic.
    always_comb begin
        n_drawn_total = r_drawn_total;
        n_exc_total   = r_exc_total;
        n_repeat      = r_repeat;
        n_mode_offer  = r_mode_offer;
        n_step        = r_step;
        n_hit         = r_hit;
        n_res_valid   = 1'b0;
        n_word        = r_word;
        n_key         = r_key;
        n_l0          = r_l0;
        n_r0          = r_r0;
        n_result      = '0;
        div_start     = 1'b0;
        div_dividend  = '0;
        drawn_ctl     = '0;
        exc_ctl       = '0;
        wr_idx        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_word       = i_item.value;
                    n_key        = i_item.value;
                    n_mode_offer = is_offer;
                    n_step       = '0;
                    n_hit        = 1'b0;
                    if (is_clear) begin
                        n_drawn_total   = '0;
                        n_exc_total     = '0;
                        n_repeat        = 1'b0;
                        n_res_valid     = 1'b1;
                        n_result.status = ST_CLEARED;
                    end else if (is_add) begin
                        if (exc_full) begin
                            n_res_valid     = 1'b1;
                            n_result.status = ST_TOO_MANY;
                        end
                    end else begin
                        n_res_valid = offer_fail;
                        priority if (bad_order) begin
                            n_result.status = ST_LOW_HIGH;
                        end else if (too_many) begin
                            n_result.status = ST_TOO_MANY;
                        end else if (over_max) begin
                            n_result.status = ST_OVER_MAX;
                        end else if (r_repeat) begin
                            n_result.status = ST_EXC_REPEAT;
                        end else if (done_all) begin
                            n_result.status = ST_COMPLETE;
                        end else begin
                            div_start    = 1'b1;
                            div_dividend = DW'(r_low);
                        end
                    end
                end
            end
            S_L0: begin
                if (div_done) begin
                    n_l0         = div_rem;
                    div_start    = 1'b1;
                    div_dividend = DW'(VALUE_MAX) - DW'(r_high);
                end
            end
            S_R0: begin
                // The top of the band equals high plus whole spans up to the maximum.
                if (div_done) begin
                    n_r0 = DW'(VALUE_MAX) - div_rem;
                end
            end
            S_BAND: begin
                if (out_band) begin
                    n_res_valid     = 1'b1;
                    n_result.status = ST_OUT_BAND;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DW'(r_word) - r_l0;
                end
            end
            S_MAP: begin
                if (div_done) begin
                    n_key = VAL_W'(div_rem + DW'(r_low));
                end
            end
            S_SEARCH: begin
                drawn_ctl.shift = 1'b1;
                exc_ctl.shift   = 1'b1;
                n_hit           = r_hit || exc_hit || (r_mode_offer && drawn_hit);
                n_step          = r_step + IDX_W'(1);
            end
            S_FINISH: begin
                n_res_valid = 1'b1;
                if (!r_mode_offer) begin
                    // A repeated exclusion is still stored and counted.
                    exc_ctl.load = 1'b1;
                    wr_idx       = r_exc_total[IDX_W-1:0];
                    n_exc_total  = r_exc_total + CNT_W'(1);
                    if (r_hit) begin
                        n_repeat        = 1'b1;
                        n_result.status = ST_EXC_REPEAT;
                    end else begin
                        n_result.status = ST_EXC_STORED;
                    end
                end else if (r_hit) begin
                    n_result.status = ST_DUPLICATE;
                end else begin
                    drawn_ctl.load       = 1'b1;
                    wr_idx               = r_drawn_total[IDX_W-1:0];
                    n_drawn_total        = r_drawn_total + CNT_W'(1);
                    n_result.status      = ST_ACCEPTED;
                    n_result.drawn_value = r_key;
                    n_result.draw_index  = IDX_OUT_W'(r_drawn_total);
                    n_result.last_draw   = (CMP_W'(r_drawn_total) + CMP_W'(1)
                                            == CMP_W'(r_draw_count));
                end
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_drawn_total <= '0;
            r_exc_total   <= '0;
            r_repeat      <= 1'b0;
            r_mode_offer  <= 1'b0;
            r_step        <= '0;
            r_hit         <= 1'b0;
            r_res_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_drawn_total <= n_drawn_total;
            r_exc_total   <= n_exc_total;
            r_repeat      <= n_repeat;
            r_mode_offer  <= n_mode_offer;
            r_step        <= n_step;
            r_hit         <= n_hit;
            r_res_valid   <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_key    <= n_key;
        r_l0     <= n_l0;
        r_r0     <= n_r0;
        r_result <= n_result;
    end

    // Configuration writes are always taken; the user must make them arrive only while idle; the block does not check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low        <= VAL_W'(1);
            r_high       <= VAL_W'(51);
            r_draw_count <= DCNT_W'(51);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RANGE_LOW:  r_low        <= i_cfg_data[VAL_W-1:0];
                REG_RANGE_HIGH: r_high       <= i_cfg_data[VAL_W-1:0];
                REG_DRAW_COUNT: r_draw_count <= i_cfg_data[DCNT_W-1:0];
                default: begin
                    r_low <= r_low;
                end
            endcase
        end
    end

    urd_div #(
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (DW'(span)),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Each cell takes its value from the next one; the last wraps to the head.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_ring
        localparam int NXT = (gi + 1) % CAPACITY;

        urd_cell u_drawn_cell (
            .i_clk     (i_clk),
            .i_ctl     (drawn_ctl),
            .i_sel     (wr_idx == IDX_W'(gi)),
            .i_next    (drawn_q[NXT]),
            .i_wr_data (r_key),
            .o_value   (drawn_q[gi])
        );

        urd_cell u_exc_cell (
            .i_clk     (i_clk),
            .i_ctl     (exc_ctl),
            .i_sel     (wr_idx == IDX_W'(gi)),
            .i_next    (exc_q[NXT]),
            .i_wr_data (r_key),
            .o_value   (exc_q[gi])
        );
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;
    assign o_cfg_ready    = 1'b1;

endmodule

>>> hdl/urd_checker.sv
`timescale 1ns / 1ps
`include "unique_random_draw_with_exclusion_unit_macros.svh"

// Port-level checks of the draw unit.
module urd_checker import urd_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_result_valid,
    input t_result              o_result
);

    // Every accepted transaction either answers at once or keeps the unit busy.
    `URD_ASSERT_NEXT(a_item_answers, start && !busy, o_result_valid || busy, "transaction lost")

    // Leaving the busy phase always comes with a result strobe.
    `URD_ASSERT_NOW(a_busy_end_result, $fell(busy), o_result_valid, "busy ended without result")

    // A result is only shown once the unit has returned to idle.
    `URD_ASSERT_NOW(a_result_idle, o_result_valid, !busy, "result while busy")

    // Only an accepted draw carries a value, an index or the last flag.
    `URD_ASSERT_NOW(a_reject_zero, o_result_valid && (o_result.status != ST_ACCEPTED),
        (o_result.drawn_value == '0) && (o_result.draw_index == '0) && !o_result.last_draw,
        "rejected result carries data")

endmodule

bind unique_random_draw_with_exclusion_unit urd_checker u_urd_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import urd_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int VALUE_MAX   = DEF_VALUE_MAX;
    localparam int ITEM_TARGET = 1150;
    // The slowest transaction is an offer, plus a random sender gap before it.
    // The limit leaves a wide margin for the whole run.
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 400;

    // Codes that the package does not name: the second offer encoding and the
    // register index that has no register behind it.
    localparam logic [1:0]           FUNC_OFFER_ALT = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_item                i_item      = '0;
    logic                 o_result_valid;
    t_result              o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    unique_random_draw_with_exclusion_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Shadow copy of the block: configuration, drawn values and exclusion list.
    // Stale entries beyond the totals are never looked at, just as in the block.
    logic [VAL_W-1:0]  cfg_range_low;
    logic [VAL_W-1:0]  cfg_range_high;
    logic [DCNT_W-1:0] cfg_draw_count;
    logic [VAL_W-1:0]  drawn_list [CAPACITY];
    int unsigned       drawn_total;
    logic [VAL_W-1:0]  excl_list [CAPACITY];
    int unsigned       excl_total;
    bit                excl_repeat;

    t_result     pending_draw_results[$];
    int unsigned items_issued  = 0;
    int unsigned fail_count    = 0;
    bit          sender_pauses = 1'b1;

    function automatic bit found_in(input logic [VAL_W-1:0] list [CAPACITY],
                                    input int unsigned n, input int unsigned v);
        for (int unsigned k = 0; k < n && k < CAPACITY; k++) begin
            if (list[k] == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Computes the answer to one transaction and advances the shadow state.
    function automatic t_result predict_draw(input t_item it);
        t_result     r;
        int unsigned lo, hi, cnt, span, l0, r0, v;
        r   = '0;
        lo  = cfg_range_low;
        hi  = cfg_range_high;
        cnt = cfg_draw_count;
        if (it.func[1]) begin
            // An offer runs the configuration checks in a fixed order first.
            span = hi - lo + 1;
            if (lo > hi) begin
                r.status = ST_LOW_HIGH;
            end else if (cnt > CAPACITY || cnt + excl_total > span) begin
                r.status = ST_TOO_MANY;
            end else if (hi > VALUE_MAX) begin
                r.status = ST_OVER_MAX;
            end else if (excl_repeat) begin
                r.status = ST_EXC_REPEAT;
            end else if (drawn_total >= cnt) begin
                r.status = ST_COMPLETE;
            end else begin
                // Words outside l0..r0 would bias the modulo mapping.
                l0 = lo % span;
                r0 = hi + ((VALUE_MAX - hi) / span) * span;
                if (it.value < l0 || it.value > r0) begin
                    r.status = ST_OUT_BAND;
                end else begin
                    v = (it.value - l0) % span + lo;
                    if (found_in(drawn_list, drawn_total, v) ||
                        found_in(excl_list, excl_total, v)) begin
                        r.status = ST_DUPLICATE;
                    end else if (drawn_total >= CAPACITY) begin
                        r.status = ST_TOO_MANY;
                    end else begin
                        drawn_list[drawn_total] = v[VAL_W-1:0];
                        r.status      = ST_ACCEPTED;
                        r.drawn_value = v[VAL_W-1:0];
                        r.draw_index  = drawn_total[IDX_OUT_W-1:0];
                        drawn_total++;
                        r.last_draw   = (drawn_total == cnt);
                    end
                end
            end
        end else if (it.func[0]) begin
            if (excl_total >= CAPACITY) begin
                r.status = ST_TOO_MANY;
            end else begin
                // A repeated exclusion is still stored, but poisons the session.
                r.status = ST_EXC_STORED;
                if (found_in(excl_list, excl_total, it.value)) begin
                    excl_repeat = 1'b1;
                    r.status    = ST_EXC_REPEAT;
                end
                excl_list[excl_total] = it.value;
                excl_total++;
            end
        end else begin
            drawn_total = 0;
            excl_total  = 0;
            excl_repeat = 1'b0;
            r.status    = ST_CLEARED;
        end
        return r;
    endfunction

    // Random words mostly span the full range; some sit at the bottom or top edge,
    // where the unbiased band starts and ends.
    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return VAL_W'($urandom_range(0, 40));
            1:       return VAL_W'($urandom_range(VALUE_MAX - 60, VALUE_MAX));
            default: return VAL_W'($urandom_range(0, VALUE_MAX));
        endcase
    endfunction

    // Presents one transaction and records its expected answer once the block takes it.
    // The start line is left high on return so that a back-to-back transaction
    // needs no second assignment in the same time step.
    task automatic send_item(input logic [1:0] func, input logic [VAL_W-1:0] value);
        int    gap;
        t_item it;
        gap = sender_pauses ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.func  = func;
        it.value = value;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_draw_results.push_back(predict_draw(it));
        items_issued++;
    endtask

    // Holds off new transactions until every outstanding answer has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_draw_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_RANGE_LOW:  cfg_range_low  = data[VAL_W-1:0];
            REG_RANGE_HIGH: cfg_range_high = data[VAL_W-1:0];
            REG_DRAW_COUNT: cfg_draw_count = data[DCNT_W-1:0];
            default: ;
        endcase
    endtask

    // Rewrites all three registers while the block is idle. Now and then the
    // unused index is written too; the block must ignore it.
    task automatic configure(input int unsigned lo, input int unsigned hi,
                             input int unsigned cnt_data);
        drain_results();
        if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, CFG_W'($urandom_range(0, VALUE_MAX)));
        write_reg(REG_RANGE_LOW, lo[CFG_W-1:0]);
        write_reg(REG_RANGE_HIGH, hi[CFG_W-1:0]);
        write_reg(REG_DRAW_COUNT, cnt_data[CFG_W-1:0]);
        i_cfg_valid <= 1'b0;
    endtask

    // Each answer must match the oldest outstanding expectation, field by field.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_draw_results.size() == 0) begin
                $error("unexpected result: status %0d, value %0d",
                       o_result.status, o_result.drawn_value);
                fail_count++;
            end else begin
                want = pending_draw_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.drawn_value !== want.drawn_value) begin
                    $error("drawn_value: expected %0d, actual %0d",
                           want.drawn_value, o_result.drawn_value);
                    fail_count++;
                end
                if (o_result.draw_index !== want.draw_index) begin
                    $error("draw_index: expected %0d, actual %0d",
                           want.draw_index, o_result.draw_index);
                    fail_count++;
                end
                if (o_result.last_draw !== want.last_draw) begin
                    $error("last_draw: expected %0d, actual %0d",
                           want.last_draw, o_result.last_draw);
                    fail_count++;
                end
            end
        end
    end

    // Hand-picked transactions under the reset configuration and a few extreme ones:
    // band edges, duplicates, both offer encodings, a repeated exclusion, a count
    // over capacity, inverted bounds, a one-value range and a count of zero.
    task automatic test_directed();
        send_item(FUNC_OFFER, 15'd0);
        send_item(FUNC_OFFER, 15'h7FFF);
        send_item(FUNC_OFFER, 15'd1);
        send_item(FUNC_OFFER, 15'd52);
        send_item(FUNC_OFFER, 15'd32742);
        send_item(FUNC_OFFER_ALT, 15'd2);
        send_item(FUNC_ADD, 15'd0);
        send_item(FUNC_OFFER, 15'd10);
        send_item(FUNC_CLEAR, 15'h7FFF);
        configure(0, VALUE_MAX, 2);
        send_item(FUNC_ADD, 15'h7FFF);
        send_item(FUNC_OFFER, 15'h7FFF);
        send_item(FUNC_OFFER, 15'd0);
        send_item(FUNC_OFFER, 15'h5555);
        send_item(FUNC_OFFER, 15'h2AAA);
        send_item(FUNC_ADD, 15'h7FFF);
        send_item(FUNC_OFFER_ALT, 15'd5);
        send_item(FUNC_CLEAR, 15'h5555);
        configure(100, 99, 1);
        send_item(FUNC_OFFER, 15'd100);
        configure(VALUE_MAX, VALUE_MAX, 1);
        send_item(FUNC_OFFER, 15'h1234);
        send_item(FUNC_OFFER, 15'h2AAA);
        configure(5, 10, 0);
        send_item(FUNC_OFFER, 15'd7);
        configure(0, VALUE_MAX, 300);
        send_item(FUNC_OFFER, 15'd9);
        configure(0, VALUE_MAX, VALUE_MAX);
        send_item(FUNC_OFFER, 15'd9);
    endtask

    // Fills the exclusion list to capacity, overflows it, then draws against a
    // full list, including a word that lands on an excluded value.
    task automatic test_exclusion_full();
        logic [VAL_W-1:0] first_excluded;
        int unsigned      tries;
        sender_pauses = 1'b1;
        configure(0, VALUE_MAX, 4);
        send_item(FUNC_CLEAR, 15'd0);
        for (int i = 0; i < CAPACITY; i++) begin
            send_item(FUNC_ADD, VAL_W'(i * 128 + $urandom_range(0, 127)));
            if (i == 0) first_excluded = excl_list[0];
        end
        send_item(FUNC_ADD, VAL_W'($urandom_range(0, VALUE_MAX)));
        send_item(FUNC_ADD, 15'h7FFF);
        send_item(FUNC_OFFER, first_excluded);
        tries = 0;
        while (drawn_total < cfg_draw_count && tries < 40) begin
            send_item(FUNC_OFFER, pick_word());
            tries++;
        end
        send_item(FUNC_OFFER, pick_word());
        send_item(FUNC_CLEAR, 15'd0);
    endtask

    // One session that draws the maximum count, so every drawn slot is used and
    // the search covers the whole drawn list. Earlier words are replayed now and
    // then to force duplicates.
    task automatic test_full_session();
        logic [VAL_W-1:0] last_word;
        int unsigned      tries;
        sender_pauses = ($urandom_range(0, 1) == 0);
        configure(0, VALUE_MAX, CAPACITY);
        send_item(FUNC_CLEAR, 15'd0);
        last_word = pick_word();
        tries = 0;
        while (drawn_total < CAPACITY && tries < 400) begin
            if ($urandom_range(0, 7) != 0) last_word = pick_word();
            send_item(FUNC_OFFER, last_word);
            tries++;
        end
        send_item(FUNC_OFFER_ALT, pick_word());
    endtask

    // Mostly complete sessions with random bounds, exclusions and words; the
    // rest are broken sessions and raw noise with arbitrary configuration.
    task automatic test_random_sessions();
        int unsigned span, lo, hi, n_excl, cnt_max, v, tries, breakage;
        while (items_issued < ITEM_TARGET) begin
            // Some sessions run back to back with no gaps at all.
            sender_pauses = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                configure($urandom_range(0, VALUE_MAX), $urandom_range(0, VALUE_MAX),
                          ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20)
                                                      : $urandom_range(0, VALUE_MAX));
                repeat ($urandom_range(4, 12)) begin
                    send_item(2'($urandom_range(0, 3)), VAL_W'($urandom_range(0, VALUE_MAX)));
                end
            end else begin
                span    = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 4096)
                                                      : $urandom_range(1, 64);
                lo      = $urandom_range(0, VALUE_MAX + 1 - span);
                hi      = lo + span - 1;
                n_excl  = (span > 1) ? $urandom_range(0, (span - 1 < 6) ? span - 1 : 6) : 0;
                cnt_max = span - n_excl;
                if (cnt_max > 16) cnt_max = 16;
                configure(lo, hi, $urandom_range(1, cnt_max));
                send_item(FUNC_CLEAR, VAL_W'($urandom_range(0, VALUE_MAX)));
                // Exclusions are distinct; a few fall outside the range.
                repeat (n_excl) begin
                    do begin
                        v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, VALUE_MAX)
                                                        : $urandom_range(lo, hi);
                    end while (found_in(excl_list, excl_total, v));
                    send_item(FUNC_ADD, VAL_W'(v));
                end
                breakage = $urandom_range(0, 7);
                tries    = 0;
                while (drawn_total < cfg_draw_count && tries < 80) begin
                    if (tries == 3 && breakage == 0) begin
                        // A late exclusion, possibly a repeat, spoils the session.
                        send_item(FUNC_ADD, VAL_W'($urandom_range(lo, hi)));
                        send_item(FUNC_OFFER, pick_word());
                        break;
                    end
                    if (tries == 3 && breakage == 1) send_item(FUNC_CLEAR, pick_word());
                    send_item(($urandom_range(0, 3) == 0) ? FUNC_OFFER_ALT : FUNC_OFFER,
                              pick_word());
                    tries++;
                end
                send_item(FUNC_OFFER, pick_word());
            end
        end
    endtask

    // Ends the run if it hangs.
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        cfg_range_low  = 15'd1;
        cfg_range_high = 15'd51;
        cfg_draw_count = 9'd51;
        drawn_total    = 0;
        excl_total     = 0;
        excl_repeat    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_exclusion_full();
        test_full_session();
        test_random_sessions();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
